// ===== rtl/core/csem_pkg.sv =====
// Shared constants, codes and types of the counting semaphore block.
package csem_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SEM_W = 17;

    localparam logic signed [SEM_W-1:0] SEM_MAX = 17'sd65535;

    localparam logic [1:0] FUNC_WAIT   = 2'd0;
    localparam logic [1:0] FUNC_SIGNAL = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_BLOCKED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic KIND_REPLY   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] ticks;
        logic        untimed;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
    } queue_wr_t;

endpackage

// ===== rtl/core/csem_queue.sv =====
// Waiter queue storage: one write port, one read port.
module csem_queue (
    input  logic                      aclk,
    input  csem_pkg::queue_wr_t       wr,
    input  logic [csem_pkg::IDX_W-1:0] rd_idx,
    output csem_pkg::entry_t          rd_entry
);

    csem_pkg::entry_t entries_reg [csem_pkg::QUEUE_DEPTH];
    csem_pkg::entry_t rd_entry_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entries_reg[wr.idx] <= wr.entry;
        end
        rd_entry_reg <= entries_reg[rd_idx];
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ===== rtl/core/counting_semaphore_timed_wait.sv =====
// Top level: counting semaphore with a FIFO of timed waiters.
//
// Input channel s_*: one transfer is one call (wait, signal or timer tick).
// Result channel m_*: each call yields zero or more release transfers
// (tuser=1) in queue order, then one reply transfer (tuser=0, tlast=1).
// Config channel cfg_*: a transfer loads the count and empties the queue;
// write it only while no call is in progress.
// Timing: a call is taken when s_tready is high, then decided in ST_EXEC.
// Calls that touch no queued entry pass from ST_EXEC to ST_REPLY, which puts
// the reply in the output register. Signal with releases and timer ticks
// scan the queue in ST_WALK, one entry per cycle while the output register
// can take a result, through the single entry read port, then go to ST_REPLY.
// s_tready is low from transfer until the reply is in the output register.
// When the receiver stalls, the scan and the reply hold while the output
// register is full; nothing is dropped.
// Reset: count 0, queue empty, no result pending.
module counting_semaphore_timed_wait (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // thread_id[7:0], timeout[23:8], count[39:24]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // released_thread[7:0], return_value[23:8],
                                   // status[25:24], zero fill
    output logic [0:0]  m_tuser,   // kind[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = csem_pkg::IDX_W;
    localparam int COUNT_W = csem_pkg::COUNT_W;
    localparam int SEM_W = csem_pkg::SEM_W;

    csem_pkg::state_t state_reg, state_next;

    logic signed [SEM_W-1:0] sem_reg, sem_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [COUNT_W-1:0]      i_reg, i_next;
    logic [COUNT_W-1:0]      w_reg, w_next;
    logic [COUNT_W-1:0]      m_reg, m_next;
    logic [1:0]              func_reg;
    logic [7:0]              tid_reg;
    logic [15:0]             tmo_reg;
    logic signed [15:0]      n_reg;
    logic signed [15:0]      rv_reg, rv_next;
    logic [1:0]              status_reg, status_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_kind_reg, out_kind_next;
    logic [7:0]              out_tid_reg, out_tid_next;
    logic signed [15:0]      out_rv_reg, out_rv_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_load;

    csem_pkg::queue_wr_t     q_wr;
    csem_pkg::entry_t        q_rd;

    logic                    out_free;
    logic                    walk_done;
    logic                    walk_step;
    logic                    is_tick;
    logic                    timed;
    logic                    drop;
    logic signed [SEM_W-1:0] sem_inc;
    logic signed [SEM_W-1:0] sem_sig0;
    logic signed [SEM_W:0]   sem_sum;
    logic [COUNT_W-1:0]      m_min;

    // registered read: address the entry the scan uses next cycle
    csem_queue u_queue (
        .aclk     (aclk),
        .wr       (q_wr),
        .rd_idx   (i_next[IDX_W-1:0]),
        .rd_entry (q_rd)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign walk_done = (i_reg == count_reg);
    assign walk_step = (state_reg == csem_pkg::ST_WALK) && !walk_done && out_free;
    assign is_tick = (func_reg == csem_pkg::FUNC_TICK);
    assign timed = !q_rd.untimed && (q_rd.ticks != 16'd0);
    assign drop = is_tick ? (timed && q_rd.ticks == 16'd1) : (i_reg < m_reg);

    assign sem_inc = (sem_reg < csem_pkg::SEM_MAX) ? sem_reg + 17'sd1 : sem_reg;
    assign sem_sig0 = sem_inc;
    assign sem_sum = $signed({sem_reg[SEM_W-1], sem_reg}) + $signed({2'b00, n_reg});
    assign m_min = (16'(count_reg) < $unsigned(n_reg)) ? count_reg
                                                       : n_reg[COUNT_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            csem_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = csem_pkg::ST_EXEC;
            end
            csem_pkg::ST_EXEC: begin
                state_next = csem_pkg::ST_REPLY;
                if (func_reg == csem_pkg::FUNC_SIGNAL && !n_reg[15] && count_reg != '0) begin
                    if (n_reg != 16'sd0 || sem_sig0[SEM_W-1] || sem_sig0 == '0) begin
                        state_next = csem_pkg::ST_WALK;
                    end
                end else if (is_tick && count_reg != '0) begin
                    state_next = csem_pkg::ST_WALK;
                end
            end
            csem_pkg::ST_WALK: begin
                if (walk_done) state_next = csem_pkg::ST_REPLY;
            end
            csem_pkg::ST_REPLY: begin
                if (out_free) state_next = csem_pkg::ST_IDLE;
            end
            default: state_next = csem_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        sem_next = sem_reg;
        count_next = count_reg;
        i_next = i_reg;
        w_next = w_reg;
        m_next = m_reg;
        rv_next = rv_reg;
        status_next = status_reg;
        q_wr = '0;
        out_load = 1'b0;
        out_kind_next = out_kind_reg;
        out_tid_next = out_tid_reg;
        out_rv_next = out_rv_reg;
        out_status_next = out_status_reg;
        out_last_next = out_last_reg;

        case (state_reg)
            csem_pkg::ST_EXEC: begin
                i_next = '0;
                w_next = '0;
                m_next = '0;
                status_next = csem_pkg::STATUS_DONE;
                rv_next = 16'sd0;
                case (func_reg)
                    csem_pkg::FUNC_WAIT: begin
                        if (!sem_reg[SEM_W-1] && sem_reg != '0) begin
                            sem_next = sem_reg - 17'sd1;
                            rv_next = 16'sd1;
                        end else if (count_reg >= COUNT_W'(csem_pkg::QUEUE_DEPTH)) begin
                            rv_next = -16'sd1;
                            status_next = csem_pkg::STATUS_FULL;
                        end else begin
                            sem_next = sem_reg - 17'sd1;
                            q_wr.en = 1'b1;
                            q_wr.idx = count_reg[IDX_W-1:0];
                            q_wr.entry.id = tid_reg;
                            q_wr.entry.ticks = tmo_reg;
                            q_wr.entry.untimed = (tmo_reg == 16'd0);
                            count_next = count_reg + COUNT_W'(1);
                            status_next = csem_pkg::STATUS_BLOCKED;
                        end
                    end
                    csem_pkg::FUNC_SIGNAL: begin
                        if (n_reg[15]) begin
                            rv_next = n_reg;
                        end else if (n_reg == 16'sd0) begin
                            sem_next = sem_sig0;
                            rv_next = 16'sd1;
                            if ((sem_sig0[SEM_W-1] || sem_sig0 == '0) && count_reg != '0) begin
                                m_next = COUNT_W'(1);
                            end
                        end else if (count_reg != '0) begin
                            m_next = m_min;
                            sem_next = sem_reg + $signed(17'(m_min));
                            rv_next = 16'(m_min);
                        end else begin
                            sem_next = (sem_sum > 18'sd65535) ? csem_pkg::SEM_MAX
                                                              : sem_sum[SEM_W-1:0];
                        end
                    end
                    csem_pkg::FUNC_TICK: begin
                        rv_next = 16'sd0;
                    end
                    default: begin
                        rv_next = -16'sd1;
                    end
                endcase
            end
            csem_pkg::ST_WALK: begin
                if (walk_done) begin
                    count_next = w_reg;
                end else if (walk_step) begin
                    i_next = i_reg + COUNT_W'(1);
                    if (drop) begin
                        out_load = 1'b1;
                        out_kind_next = csem_pkg::KIND_RELEASE;
                        out_tid_next = q_rd.id;
                        out_rv_next = is_tick ? 16'sd0 : 16'sd1;
                        out_status_next = csem_pkg::STATUS_DONE;
                        out_last_next = 1'b0;
                        if (is_tick) sem_next = sem_inc;
                    end else begin
                        q_wr.en = 1'b1;
                        q_wr.idx = w_reg[IDX_W-1:0];
                        q_wr.entry.id = q_rd.id;
                        q_wr.entry.untimed = q_rd.untimed;
                        q_wr.entry.ticks = (is_tick && timed) ? q_rd.ticks - 16'd1
                                                              : q_rd.ticks;
                        w_next = w_reg + COUNT_W'(1);
                    end
                end
            end
            csem_pkg::ST_REPLY: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind_next = csem_pkg::KIND_REPLY;
                    out_tid_next = 8'd0;
                    out_rv_next = rv_reg;
                    out_status_next = status_reg;
                    out_last_next = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (cfg_valid) begin
            sem_next = $signed({1'b0, cfg_data});
            count_next = '0;
        end

        if (out_load) out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csem_pkg::ST_IDLE;
            sem_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sem_reg <= sem_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg <= s_tuser;
            tid_reg <= s_tdata[7:0];
            tmo_reg <= s_tdata[23:8];
            n_reg <= $signed(s_tdata[39:24]);
        end
        i_reg <= i_next;
        w_reg <= w_next;
        m_reg <= m_next;
        rv_reg <= rv_next;
        status_reg <= status_next;
        out_kind_reg <= out_kind_next;
        out_tid_reg <= out_tid_next;
        out_rv_reg <= out_rv_next;
        out_status_reg <= out_status_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == csem_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, out_status_reg, out_rv_reg, out_tid_reg};
    assign m_tuser = out_kind_reg;
    assign m_tlast = out_last_reg;

`ifndef SYNTHESIS
    a_sem_matches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == csem_pkg::ST_IDLE && sem_reg[SEM_W-1])
        |-> (-sem_reg == $signed(17'(count_reg))))
        else $error("negative count does not match queued waiters");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(csem_pkg::QUEUE_DEPTH))
        else $error("waiter count beyond queue depth");

    a_compact_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == csem_pkg::ST_WALK) |-> (w_reg <= i_reg && i_reg <= count_reg))
        else $error("queue scan pointers out of order");

    a_last_is_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast != m_tuser[0]))
        else $error("tlast must mark exactly the reply");
`endif

endmodule

// ===== tb/counting_semaphore_timed_wait_test.sv =====
`timescale 1ns / 100ps
// Self-checking stream bench for the counting semaphore with timed waiters.
module counting_semaphore_timed_wait_test;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENT_CALLS = 25;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic        kind;
        logic [7:0]  thread;
        logic [15:0] value;
        logic [1:0]  status;
        logic        last;
    } sem_result_t;

    class semaphore_tracker;
        int          count;
        logic [7:0]  ids[csem_pkg::QUEUE_DEPTH];
        logic [15:0] ticks[csem_pkg::QUEUE_DEPTH];
        bit          forever_wait[csem_pkg::QUEUE_DEPTH];
        int          depth;
        sem_result_t due_results[$];
        int          errors;
        int          calls;
        int          blocked;
        int          refused;
        int          signal_releases;
        int          timeout_releases;

        function void load(logic [15:0] value);
            count = int'(value);
            depth = 0;
        endfunction

        function void post(logic kind, logic [7:0] thread, int value, logic [1:0] status,
                           logic last);
            sem_result_t r;
            r.kind   = kind;
            r.thread = thread;
            r.value  = value[15:0];
            r.status = status;
            r.last   = last;
            due_results.push_back(r);
        endfunction

        function void unlink(int pos);
            for (int i = pos; i < depth - 1; i++) begin
                ids[i]          = ids[i + 1];
                ticks[i]        = ticks[i + 1];
                forever_wait[i] = forever_wait[i + 1];
            end
            depth--;
        endfunction

        function void release_oldest();
            post(csem_pkg::KIND_RELEASE, ids[0], 1, csem_pkg::STATUS_DONE, 1'b0);
            signal_releases++;
            unlink(0);
        endfunction

        function void take_call(logic [1:0] func, logic [7:0] thread, logic [15:0] timeout,
                                logic [15:0] amount);
            int         n;
            int         reply;
            int         m;
            int         i;
            logic [1:0] status;
            n = int'($signed(amount));
            reply = 0;
            status = csem_pkg::STATUS_DONE;
            calls++;
            case (func)
                csem_pkg::FUNC_WAIT: begin
                    if (count > 0) begin
                        count--;
                        reply = 1;
                    end else if (depth >= csem_pkg::QUEUE_DEPTH) begin
                        reply = -1;
                        status = csem_pkg::STATUS_FULL;
                        refused++;
                    end else begin
                        count--;
                        ids[depth] = thread;
                        ticks[depth] = timeout;
                        forever_wait[depth] = (timeout == 16'd0);
                        depth++;
                        status = csem_pkg::STATUS_BLOCKED;
                        blocked++;
                    end
                end
                csem_pkg::FUNC_SIGNAL: begin
                    if (n < 0) begin
                        reply = n;
                    end else if (n == 0) begin
                        if (count < int'(csem_pkg::SEM_MAX)) count++;
                        if (count <= 0 && depth > 0) release_oldest();
                        reply = 1;
                    end else if (depth > 0) begin
                        m = (depth < n) ? depth : n;
                        for (i = 0; i < m; i++) release_oldest();
                        count += m;
                        reply = m;
                    end else begin
                        count += n;
                        if (count > int'(csem_pkg::SEM_MAX)) count = int'(csem_pkg::SEM_MAX);
                    end
                end
                csem_pkg::FUNC_TICK: begin
                    i = 0;
                    while (i < depth) begin
                        if (!forever_wait[i] && ticks[i] != 16'd0) ticks[i] = ticks[i] - 16'd1;
                        if (!forever_wait[i] && ticks[i] == 16'd0) begin
                            post(csem_pkg::KIND_RELEASE, ids[i], 0, csem_pkg::STATUS_DONE,
                                 1'b0);
                            timeout_releases++;
                            unlink(i);
                            if (count < int'(csem_pkg::SEM_MAX)) count++;
                        end else begin
                            i++;
                        end
                    end
                end
                default: reply = -1;
            endcase
            post(csem_pkg::KIND_REPLY, 8'd0, reply, status, 1'b1);
        endfunction

        function void flag_field(string field, int want, int got);
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        endfunction

        function void match_result(sem_result_t got);
            sem_result_t want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing got %h",
                         $time, got);
                return;
            end
            want = due_results.pop_front();
            if (got.kind != want.kind) flag_field("kind", want.kind, got.kind);
            if (got.thread != want.thread) flag_field("released_thread", want.thread, got.thread);
            if (got.value != want.value)
                flag_field("return_value", int'($signed(want.value)), int'($signed(got.value)));
            if (got.status != want.status) flag_field("status", want.status, got.status);
            if (got.last != want.last) flag_field("tlast", want.last, got.last);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // thread_id[7:0], timeout[23:8], count[39:24]
    logic [1:0]  s_tuser = '0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // released_thread[7:0], return_value[23:8], status[25:24]
    logic [0:0]  m_tuser;        // kind[0]
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    semaphore_tracker tracker = new();
    int source_gap_pct = 16;
    int sink_stall_pct = 74;
    int cycle_count = 0;
    int settings_loaded = 0;
    logic [15:0] count_plan[9] = '{16'd0, 16'hFFFF, 16'd2, 16'd0, 16'd1, 16'h8000,
                                   16'd0, 16'd4, 16'd0};

    counting_semaphore_timed_wait dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.match_result(sem_result_t'({m_tuser[0], m_tdata[7:0], m_tdata[23:8],
                                                m_tdata[25:24], m_tlast}));
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_call(input logic [1:0] func, input logic [7:0] thread,
                             input logic [15:0] timeout, input logic [15:0] amount);
        @(negedge aclk);
        while ($urandom_range(99) < source_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {amount, timeout, thread};
        do @(posedge aclk); while (!s_tready);
        tracker.take_call(func, thread, timeout, amount);
    endtask

    // hold off new calls until every outstanding result has been taken
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_count(input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.load(value);
        settings_loaded++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_call();
        logic [1:0]  func;
        logic [15:0] timeout;
        logic [15:0] amount;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 42) func = csem_pkg::FUNC_WAIT;
        else if (pick < 70) func = csem_pkg::FUNC_SIGNAL;
        else if (pick < 95) func = csem_pkg::FUNC_TICK;
        else func = FUNC_UNUSED;
        pick = $urandom_range(99);
        if (pick < 25) timeout = 16'd0;
        else if (pick < 85) timeout = 16'($urandom_range(1, 6));
        else if (pick < 95) timeout = 16'($urandom_range(7, 40));
        else timeout = 16'($urandom_range(65535));
        pick = $urandom_range(99);
        if (pick < 35) amount = 16'd0;
        else if (pick < 75) amount = 16'($urandom_range(1, 5));
        else if (pick < 85) amount = 16'($urandom_range(6, 40));
        else if (pick < 93) amount = 16'($urandom_range(32768, 65535));
        else amount = 16'($urandom_range(32767));
        send_call(func, 8'($urandom_range(255)), timeout, amount);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_count(16'd0);
        send_call(csem_pkg::FUNC_WAIT, 8'hFF, 16'd0, 16'd0);
        send_call(csem_pkg::FUNC_WAIT, 8'h00, 16'd1, 16'd0);
        send_call(csem_pkg::FUNC_WAIT, 8'hA5, 16'hFFFF, 16'd0);
        send_call(csem_pkg::FUNC_TICK, 8'h5A, 16'd0, 16'd0);
        send_call(csem_pkg::FUNC_SIGNAL, 8'd0, 16'd0, 16'd0);
        send_call(csem_pkg::FUNC_SIGNAL, 8'd0, 16'd0, 16'h8000);
        send_call(csem_pkg::FUNC_SIGNAL, 8'd0, 16'd0, 16'h7FFF);
        send_call(FUNC_UNUSED, 8'h3C, 16'h1234, 16'hFFFF);
        drain_results();

        // fill the waiter queue, then one more wait must be refused
        set_count(16'd0);
        for (int i = 0; i <= csem_pkg::QUEUE_DEPTH; i++)
            send_call(csem_pkg::FUNC_WAIT, 8'(i * 17), (i % 3 == 0) ? 16'd0 : 16'd1, 16'd0);
        send_call(csem_pkg::FUNC_TICK, 8'd0, 16'd0, 16'd0);
        send_call(csem_pkg::FUNC_SIGNAL, 8'd0, 16'd0, 16'h7FFF);

        for (int phase = 0; phase < 3; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    source_gap_pct = 16;
                    sink_stall_pct = 74;
                end
                1: begin
                    source_gap_pct = 74;
                    sink_stall_pct = 16;
                end
                default: begin
                    source_gap_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                drain_results();
                set_count(count_plan[phase * 3 + seg]);
                for (int k = 0; k < SEGMENT_CALLS; k++) begin
                    if ($urandom_range(49) == 0) drain_results();
                    random_call();
                end
            end
        end

        drain_results();
        repeat (20) @(posedge aclk);
        $display("ran %0d calls over %0d count settings: %0d waits blocked, %0d refused full",
                 tracker.calls, settings_loaded, tracker.blocked, tracker.refused);
        $display("waiters freed: %0d by signal, %0d by timeout",
                 tracker.signal_releases, tracker.timeout_releases);
        if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
